// File: rtl/npts_pkg.sv
// shared types and widths for the nearest point search block
`timescale 1ns / 1ps
`default_nettype none

package npts_pkg;

    // widths of the result fields as they leave the block, and of an input coordinate
    localparam int unsigned IDX_OUT_W   = 10;
    localparam int unsigned DIST_OUT_W  = 33;
    localparam int unsigned COUNT_OUT_W = 11;
    localparam int unsigned IN_COORD_W  = 16;

    // control word that travels beside each read of the point store
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } npts_ctl_t;

endpackage

`default_nettype wire

// File: rtl/nearest_point_search.sv
// top level of the nearest point search block
// Usage: each input item on the s_ channel carries an operation in s_tuser
// (load point, query nearest, clear store) and a point in s_tdata. Every
// item gives exactly one result item on the m_ channel: nearest index,
// squared distance and point count in m_tdata, status in m_tuser.
// Items are handled one at a time. A load, a clear or a query on an empty
// store goes straight to its reply without reading the point memory. A query
// over N stored points reads the point memory once per point, one address per
// cycle, through the single read port, and then waits for the distance pipeline
// to drain before it replies.
// Results go through an output register: the next item is taken while a
// finished result still waits, and a stalled receiver holds m_tvalid and
// m_tdata steady until m_tready. The block then waits with that next
// item's result until the register is free.
// Reset (aresetn low, synchronous) empties the store; point memory contents
// are not cleared and are never read before being loaded.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_search
    import npts_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // coord_x [15:0], coord_y [31:16]
    input  wire logic [1:0]  s_tuser,   // func [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // nearest_index [9:0], squared_distance [42:10],
                                        // point_count [53:43], zero [55:54]
    output logic [1:0]       m_tuser    // status [1:0]
);

    localparam int unsigned COORD_W = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int unsigned IDX_W   = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int unsigned DIST_W  = 2 * COORD_W + 1;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        REPLY
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic [COORD_W-1:0] qx_reg;
    logic [COORD_W-1:0] qy_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    status_t            res_status_reg;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    func_t              in_func;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic               in_accept;
    logic               full;
    logic               wr_en;
    npts_ctl_t          rd_ctl;
    npts_ctl_t          st_ctl;
    logic [COORD_W-1:0] st_x;
    logic [COORD_W-1:0] st_y;
    logic               dist_done;
    logic [IDX_W-1:0]   best_index;
    logic [DIST_W-1:0]  best_dist;
    logic               scan_last;

    assign in_func   = func_t'(s_tuser);
    assign in_x      = s_tdata[COORD_W-1:0];
    assign in_y      = s_tdata[IN_COORD_W+COORD_W-1:IN_COORD_W];
    assign s_tready  = (state_reg == IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign wr_en     = in_accept && (in_func == FUNC_LOAD) && !full;
    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);

    assign rd_ctl.valid = (state_reg == SCAN);
    assign rd_ctl.first = (scan_reg == '0);
    assign rd_ctl.last  = scan_last;

    npts_store #(
        .DEPTH   (MAX_POINTS),
        .COORD_W (COORD_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    (count_reg[IDX_W-1:0]),
        .wr_x       (in_x),
        .wr_y       (in_y),
        .rd_ctl     (rd_ctl),
        .rd_addr    (scan_reg),
        .rd_ctl_out (st_ctl),
        .rd_x       (st_x),
        .rd_y       (st_y)
    );

    npts_dist #(
        .DEPTH   (MAX_POINTS),
        .COORD_W (COORD_W)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .in_ctl     (st_ctl),
        .px         (st_x),
        .py         (st_y),
        .done       (dist_done),
        .best_index (best_index),
        .best_dist  (best_dist)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == REPLY) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (in_accept) begin
                        res_idx_reg    <= '0;
                        res_dist_reg   <= '0;
                        res_status_reg <= STAT_OK;
                        qx_reg         <= in_x;
                        qy_reg         <= in_y;
                        scan_reg       <= '0;
                        state_reg      <= REPLY;
                        unique case (in_func)
                            FUNC_LOAD: begin
                                if (full) begin
                                    res_status_reg <= STAT_FULL;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            FUNC_QUERY: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= STAT_EMPTY;
                                end else begin
                                    state_reg <= SCAN;
                                end
                            end
                            FUNC_CLEAR: begin
                                count_reg <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                SCAN: begin
                    if (scan_last) begin
                        state_reg <= DRAIN;
                    end else begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end
                DRAIN: begin
                    // wait for the last point to leave the distance pipeline
                    if (dist_done) begin
                        res_idx_reg  <= best_index;
                        res_dist_reg <= best_dist;
                        state_reg    <= REPLY;
                    end
                end
                REPLY: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {2'b00,
                                         COUNT_OUT_W'(count_reg),
                                         DIST_OUT_W'(res_dist_reg),
                                         IDX_OUT_W'(res_idx_reg)};
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: rtl/npts_store.sv
// point store: one synchronous memory holding x and y of every loaded point
`timescale 1ns / 1ps
`default_nettype none

module npts_store
    import npts_pkg::*;
#(
    parameter int unsigned DEPTH   = 1024,
    parameter int unsigned COORD_W = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [COORD_W-1:0]       wr_x,
    input  wire logic [COORD_W-1:0]       wr_y,
    input  wire npts_ctl_t                rd_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output npts_ctl_t                     rd_ctl_out,
    output logic      [COORD_W-1:0]       rd_x,
    output logic      [COORD_W-1:0]       rd_y
);

    logic [2*COORD_W-1:0] mem [DEPTH];
    logic [2*COORD_W-1:0] rd_data_reg;
    npts_ctl_t            ctl_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_y, wr_x};
        end
        if (rd_ctl.valid) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control is registered alongside the read data, so it stays aligned with it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= rd_ctl;
        end
    end

    assign rd_ctl_out = ctl_reg;
    assign rd_x       = rd_data_reg[COORD_W-1:0];
    assign rd_y       = rd_data_reg[2*COORD_W-1:COORD_W];

endmodule

`default_nettype wire

// File: rtl/npts_dist.sv
// distance pipeline: abs difference, squares, sum and running minimum
`timescale 1ns / 1ps
`default_nettype none

module npts_dist
    import npts_pkg::*;
#(
    parameter int unsigned DEPTH   = 1024,
    parameter int unsigned COORD_W = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [COORD_W-1:0]       qx,
    input  wire logic [COORD_W-1:0]       qy,
    input  wire npts_ctl_t                in_ctl,
    input  wire logic [COORD_W-1:0]       px,
    input  wire logic [COORD_W-1:0]       py,
    output logic                          done,
    output logic [$clog2(DEPTH)-1:0]      best_index,
    output logic [2*COORD_W:0]            best_dist
);

    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned SQ_W   = 2 * COORD_W;
    localparam int unsigned DIST_W = SQ_W + 1;

    npts_ctl_t          c1_reg;
    npts_ctl_t          c2_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]   bidx_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [DIST_W-1:0]  sum;

    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg   <= '0;
            c2_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            c1_reg   <= in_ctl;
            c2_reg   <= c1_reg;
            done_reg <= c2_reg.valid && c2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= (qx >= px) ? (qx - px) : (px - qx);
        dy_reg  <= (qy >= py) ? (qy - py) : (py - qy);
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        if (c2_reg.valid) begin
            // strictly smaller only, so ties keep the lower index
            if (c2_reg.first) begin
                best_reg <= sum;
                bidx_reg <= '0;
                cnt_reg  <= IDX_W'(1);
            end else begin
                if (sum < best_reg) begin
                    best_reg <= sum;
                    bidx_reg <= cnt_reg;
                end
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
        end
    end

    assign done       = done_reg;
    assign best_index = bidx_reg;
    assign best_dist  = best_reg;

endmodule

`default_nettype wire
